### hw/rtl/asgr_pkg.sv
// Shared types, codes and character constants for the SGR escape stripper.
package asgr_pkg;

	// Characters that the parser recognizes.
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_END   = 8'h6D;
	localparam logic [7:0] CH_SEP   = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// A number takes a digit only up to this value; larger values saturate.
	localparam logic [6:0] NUM_LIMIT = 7'd108;
	localparam logic [6:0] NUM_SAT   = 7'd109;

	// Parser mode.
	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_NUM1,
		MODE_NUM2
	} mode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAIN_RD,
		ST_PLAIN_OUT,
		ST_BYTE,
		ST_TAIL_RD,
		ST_TAIL_OUT
	} ctl_state_t;

	// Source of the byte loaded into the output register.
	typedef enum logic [1:0] {
		OSEL_IN,
		OSEL_SAVED,
		OSEL_PEND,
		OSEL_MARK
	} osel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  accept;
		logic  idx_clr;
		logic  idx_inc;
		logic  rd_en;
		logic  out_load;
		osel_t out_sel;
		logic  out_tail;
		logic  out_done;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic in_end;
		logic dec_plain;
		logic dec_tail;
		logic dec_emit;
		logic dec_marker;
		logic plan_emit;
		logic plan_tail;
		logic plan_end;
		logic idx_last_plain;
		logic idx_last_tail;
	} sts_t;

endpackage

### hw/rtl/asgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/asgr_ctrl.sv
// Controller state machine that sequences accepts, flushes and output loads.
module asgr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  asgr_pkg::sts_t sts,
	output asgr_pkg::cmd_t cmd,
	output logic          in_stall
);

	import asgr_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.out_sel = OSEL_IN;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !sts.out_free;
				if (in_valid && sts.out_free) begin
					cmd.accept = 1'b1;
					if (sts.dec_plain) begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_PLAIN_RD;
					end else if (sts.dec_tail) begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_TAIL_RD;
					end else if (sts.dec_emit) begin
						// Plain text goes straight to the output register.
						cmd.out_load = 1'b1;
						cmd.out_sel  = OSEL_IN;
						cmd.out_done = sts.in_end;
					end else if (sts.dec_marker) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = OSEL_MARK;
						cmd.out_done = 1'b1;
					end
				end
			end
			ST_PLAIN_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_PLAIN_OUT;
			end
			ST_PLAIN_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_PEND;
					cmd.out_done = sts.plan_end && sts.idx_last_plain
						&& !sts.plan_emit && !sts.plan_tail;
					if (!sts.idx_last_plain) begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_PLAIN_RD;
					end else if (sts.plan_emit) begin
						state_d = ST_BYTE;
					end else if (sts.plan_tail) begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_TAIL_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_BYTE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_SAVED;
					cmd.out_done = sts.plan_end && !sts.plan_tail;
					if (sts.plan_tail) begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_TAIL_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_TAIL_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_TAIL_OUT;
			end
			ST_TAIL_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_PEND;
					cmd.out_tail = 1'b1;
					cmd.out_done = sts.plan_end && sts.idx_last_tail;
					if (sts.idx_last_tail) begin
						state_d = ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_TAIL_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/asgr_dp.sv
// Datapath: parser state, byte classification, pending store and output register.
module asgr_dp #(
	parameter int MAX_PENDING = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	input  logic           out_stall,
	input  asgr_pkg::cmd_t cmd,
	output asgr_pkg::sts_t sts,
	output logic           out_valid,
	output logic [7:0]     out_byte,
	output logic           goes_to_tail,
	output logic           carries_byte,
	output logic           text_done
);

	import asgr_pkg::*;

	localparam int CW = $clog2(MAX_PENDING + 1);
	localparam int AW = $clog2(MAX_PENDING);

	// Parser state.
	mode_t         mode_q;
	logic [6:0]    num_q;
	logic [CW-1:0] cnt_q;

	// Plan of the accepted item's flush work.
	logic [CW-1:0] plan_nplain_q;
	logic [CW-1:0] plan_ntail_q;
	logic [7:0]    plan_byte_q;
	logic          plan_emit_q;
	logic          plan_end_q;
	logic [CW-1:0] rd_idx_q;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_tail_q;
	logic          out_carries_q;
	logic          out_done_q;

	// Decode results.
	mode_t         mode_d;
	logic [6:0]    num_d;
	logic [CW-1:0] cnt_d;
	logic          flush_old;
	logic          emit;
	logic          store;
	logic          waddr_zero;
	logic          full;
	logic          digit;
	logic          num_open;
	logic [10:0]   num_ext;
	logic [CW-1:0] nplain;
	logic [CW-1:0] ntail;
	logic          marker;
	logic [AW-1:0] waddr;
	logic [7:0]    ram_rdata;
	logic          out_free;

	// Classify the incoming byte and work out the parser's next state.
	always_comb begin
		mode_d     = mode_q;
		num_d      = num_q;
		cnt_d      = cnt_q;
		flush_old  = 1'b0;
		emit       = 1'b0;
		store      = 1'b0;
		waddr_zero = 1'b0;
		full       = (cnt_q == CW'(MAX_PENDING));
		digit      = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
		num_open   = digit && (num_q <= NUM_LIMIT);
		num_ext    = (11'(num_q) * 11'd10) + 11'(text_byte[3:0]);
		priority if (mode_q == MODE_ESC && text_byte != CH_OPEN) begin
			// ESC not followed by '[': flush it, then treat this byte as fresh text.
			flush_old = 1'b1;
			if (text_byte == CH_ESC) begin
				store      = 1'b1;
				waddr_zero = 1'b1;
				mode_d     = MODE_ESC;
				num_d      = '0;
				cnt_d      = CW'(1);
			end else begin
				emit   = 1'b1;
				mode_d = MODE_PLAIN;
				num_d  = '0;
				cnt_d  = '0;
			end
		end else if (mode_q == MODE_PLAIN) begin
			if (text_byte == CH_ESC) begin
				store      = 1'b1;
				waddr_zero = 1'b1;
				mode_d     = MODE_ESC;
				cnt_d      = CW'(1);
			end else begin
				emit = 1'b1;
			end
		end else if (mode_q == MODE_ESC || num_open
				|| (mode_q == MODE_NUM1 && text_byte == CH_SEP)) begin
			// Byte joins the sequence, unless the pending store is full.
			if (full) begin
				flush_old = 1'b1;
				emit      = 1'b1;
				mode_d    = MODE_PLAIN;
				num_d     = '0;
				cnt_d     = '0;
			end else begin
				store = 1'b1;
				cnt_d = cnt_q + CW'(1);
				priority if (mode_q == MODE_ESC) begin
					mode_d = MODE_NUM1;
					num_d  = '0;
				end else if (num_open) begin
					num_d = (num_ext > 11'(NUM_LIMIT)) ? NUM_SAT : num_ext[6:0];
				end else begin
					mode_d = MODE_NUM2;
					num_d  = '0;
				end
			end
		end else if (text_byte == CH_END) begin
			// Completed sequence is dropped.
			mode_d = MODE_PLAIN;
			num_d  = '0;
			cnt_d  = '0;
		end else begin
			// Broken sequence goes out as plain text with the breaking byte.
			flush_old = 1'b1;
			emit      = 1'b1;
			mode_d    = MODE_PLAIN;
			num_d     = '0;
			cnt_d     = '0;
		end

		nplain = flush_old ? cnt_q : '0;
		ntail  = (end_of_text && mode_d != MODE_PLAIN) ? cnt_d : '0;
		marker = end_of_text && (nplain == '0) && !emit && (ntail == '0);
		if (end_of_text) begin
			mode_d = MODE_PLAIN;
			num_d  = '0;
			cnt_d  = '0;
		end
	end

	assign waddr = waddr_zero ? '0 : cnt_q[AW-1:0];

	// Pending bytes of the open sequence.
	asgr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PENDING)
	) u_pend_ram (
		.clk   (clk),
		.we    (cmd.accept && store),
		.waddr (waddr),
		.wdata (text_byte),
		.re    (cmd.rd_en),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Parser state and plan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_PLAIN;
			num_q         <= '0;
			cnt_q         <= '0;
			plan_nplain_q <= '0;
			plan_ntail_q  <= '0;
			plan_emit_q   <= 1'b0;
			plan_end_q    <= 1'b0;
		end else if (cmd.accept) begin
			mode_q        <= mode_d;
			num_q         <= num_d;
			cnt_q         <= cnt_d;
			plan_nplain_q <= nplain;
			plan_ntail_q  <= ntail;
			plan_emit_q   <= emit;
			plan_end_q    <= end_of_text;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			plan_byte_q <= text_byte;
		end
	end

	// Read index of the flush in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.idx_clr) begin
			rd_idx_q <= '0;
		end else if (cmd.idx_inc) begin
			rd_idx_q <= rd_idx_q + CW'(1);
		end
	end

	// Output register; a new result loads when the old one is gone or leaves now.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_tail_q <= cmd.out_tail;
			out_done_q <= cmd.out_done;
			unique case (cmd.out_sel)
				OSEL_IN: begin
					out_byte_q    <= text_byte;
					out_carries_q <= 1'b1;
				end
				OSEL_SAVED: begin
					out_byte_q    <= plan_byte_q;
					out_carries_q <= 1'b1;
				end
				OSEL_PEND: begin
					out_byte_q    <= ram_rdata;
					out_carries_q <= 1'b1;
				end
				OSEL_MARK: begin
					out_byte_q    <= '0;
					out_carries_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign goes_to_tail = out_tail_q;
	assign carries_byte = out_carries_q;
	assign text_done    = out_done_q;

	// Status toward the controller.
	always_comb begin
		sts                = '0;
		sts.out_free       = out_free;
		sts.in_end         = end_of_text;
		sts.dec_plain      = (nplain != '0);
		sts.dec_tail       = (ntail != '0);
		sts.dec_emit       = emit;
		sts.dec_marker     = marker;
		sts.plan_emit      = plan_emit_q;
		sts.plan_tail      = (plan_ntail_q != '0);
		sts.plan_end       = plan_end_q;
		sts.idx_last_plain = ((rd_idx_q + CW'(1)) == plan_nplain_q);
		sts.idx_last_tail  = ((rd_idx_q + CW'(1)) == plan_ntail_q);
	end

	// The pending count never passes the store's depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PENDING))
		else $error("pending count beyond store depth");

	// Plain mode holds no pending bytes, and an open sequence holds at least one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PLAIN) == (cnt_q == '0))
		else $error("pending count disagrees with parser mode");

	// The running number stays at or below its saturation value.
	assert property (@(posedge clk) disable iff (!arst_n)
		num_q <= NUM_SAT)
		else $error("running number beyond saturation");

	// A result is never loaded over one that is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten while stalled");

	// A flush never reads past the end of the pending store.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (rd_idx_q < CW'(MAX_PENDING)))
		else $error("pending read out of range");

endmodule

### hw/rtl/ansi_sgr_escape_stripper.sv
// Top level of the SGR escape stripper: controller plus datapath.
// Text enters one byte per transfer and plain bytes leave one per transfer. When a
// sequence breaks or the text ends inside one, the pending bytes are read back from the
// pending RAM, each with a read state and then an output load, and the byte that broke
// the sequence follows unless it is an ESC that opens a new one; input is stalled
// during that flush. A completed color sequence produces no output. Every transfer with
// end_of_text set yields at least one result, the last of them marked with text_done.
// The pending RAM holds MAX_PENDING bytes and needs no clearing after reset.
module ansi_sgr_escape_stripper #(
	parameter int MAX_PENDING = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       goes_to_tail,
	output logic       carries_byte,
	output logic       text_done
);

	import asgr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencing of accepts and flushes.
	asgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// Parser, pending store and output register.
	asgr_dp #(
		.MAX_PENDING (MAX_PENDING)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.goes_to_tail (goes_to_tail),
		.carries_byte (carries_byte),
		.text_done    (text_done)
	);

endmodule
